FILE: sv/dedc_pkg.sv
// ----------------------------------------------------------------------------
// dedc_pkg: shared definitions for the debounced encoder digit counter
// Phase codes, register indexes, reset values and the seven-segment decode.
// ----------------------------------------------------------------------------
package dedc_pkg;

   // Field and register widths
   localparam int unsigned TIMER_W = 16;
   localparam int unsigned COUNT_W = 4;
   localparam int unsigned SEG_W   = 7;
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned ADDR_W  = 3;

   // Register reset values and digit limit
   localparam logic [TIMER_W-1:0] DEBOUNCE_RESET  = 16'd8;
   localparam logic [COUNT_W-1:0] COUNT_MAX_RESET = 4'd9;
   localparam logic [COUNT_W-1:0] DIGIT_LIMIT     = 4'd9;

   // Register index, taken from paddr[2] (registers at byte 0 and 4)
   localparam logic REG_DEBOUNCE  = 1'b0;
   localparam logic REG_COUNT_MAX = 1'b1;

   // Encoder tracking phase
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_WAIT = 2'd1,
      PH_HIGH = 2'd2
   } phase_type;

   // Active-low segment pattern, bit 0 = a .. bit 6 = g; non-digits blank
   function automatic logic [SEG_W-1:0] seg_decode_n(input logic [COUNT_W-1:0] digit);
      logic [SEG_W-1:0] seg_on;
      case (digit)
         4'd0:    seg_on = 7'h3F;
         4'd1:    seg_on = 7'h06;
         4'd2:    seg_on = 7'h5B;
         4'd3:    seg_on = 7'h4F;
         4'd4:    seg_on = 7'h66;
         4'd5:    seg_on = 7'h6D;
         4'd6:    seg_on = 7'h7D;
         4'd7:    seg_on = 7'h07;
         4'd8:    seg_on = 7'h7F;
         4'd9:    seg_on = 7'h6F;
         default: seg_on = 7'h00;
      endcase
      return ~seg_on;
   endfunction

endpackage

FILE: sv/debounced_encoder_digit_counter.sv
// ----------------------------------------------------------------------------
// debounced_encoder_digit_counter
// Debounced rotary encoder step tracking with a saturating 0..9 count and an
// active-low seven-segment drive, one pin sample per request.
// ----------------------------------------------------------------------------
//
//   Channel  | Ports                                   | Role
//   ---------+-----------------------------------------+-----------------------
//   req      | req_valid/ready, clk_level, dt_level     | one pin sample (tick)
//   rsp      | rsp_valid/ready, count_value,            | count, segments, step
//            |   segments_n, count_changed              |
//   csr      | psel, penable, pwrite, paddr, pwdata,    | debounce_ticks (0x0),
//            |   prdata, pready                         | count_max (0x4)
//
// For each request, the state update and segment decode sit
// between the state registers and the response register.
// A new request is taken every cycle while the response register is empty or
// being drained in the same cycle; a stalled response holds only the input.
// Reset is synchronous and returns the tracker to idle with the clock pin
// assumed high (pulled up), the count at zero and registers at their defaults.
// ----------------------------------------------------------------------------
module debounced_encoder_digit_counter
   import dedc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_clk_level,
   input  logic                req_dt_level,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [COUNT_W-1:0]  rsp_count_value,
   output logic [SEG_W-1:0]    rsp_segments_n,
   output logic                rsp_count_changed,
   // configuration port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]   prdata,
   output logic                pready
);

   // Configuration registers
   logic [TIMER_W-1:0] debounce_ff;
   logic [COUNT_W-1:0] count_max_ff;

   // Tracker state
   phase_type          phase_ff, phase_in;
   logic [TIMER_W-1:0] wait_timer_ff, wait_timer_in;
   logic               prev_clk_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               changed_in;

   // Response register
   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [SEG_W-1:0]   rsp_seg_ff;
   logic               rsp_changed_ff;

   logic               req_fire;
   logic               csr_write;
   logic [COUNT_W-1:0] limit;
   logic [TIMER_W-1:0] timer_inc;

   // Handshakes
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   // Register read mux
   always_comb begin
      case (paddr[2])
         REG_DEBOUNCE:  prdata = {{(DATA_W-TIMER_W){1'b0}}, debounce_ff};
         REG_COUNT_MAX: prdata = {{(DATA_W-COUNT_W){1'b0}}, count_max_ff};
         default:       prdata = '0;
      endcase
   end

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= DEBOUNCE_RESET;
         count_max_ff <= COUNT_MAX_RESET;
      end else if (csr_write) begin
         if (paddr[2] == REG_DEBOUNCE) begin
            debounce_ff <= pwdata[TIMER_W-1:0];
         end
         if (paddr[2] == REG_COUNT_MAX) begin
            count_max_ff <= pwdata[COUNT_W-1:0];
         end
      end
   end

   // Clamp the limit to a single digit
   assign limit     = (count_max_ff > DIGIT_LIMIT) ? DIGIT_LIMIT : count_max_ff;
   assign timer_inc = wait_timer_ff + TIMER_W'(1);

   // Next state for one sample
   always_comb begin
      phase_in      = phase_ff;
      wait_timer_in = wait_timer_ff;
      count_in      = count_ff;
      changed_in    = 1'b0;

      // advance the debounce wait or look for a falling clock edge
      case (phase_ff)
         PH_WAIT: begin
            wait_timer_in = timer_inc;
            if (timer_inc >= debounce_ff) begin
               phase_in = PH_HIGH;
            end
         end
         PH_HIGH: begin
            phase_in = PH_HIGH;
         end
         default: begin
            phase_in = PH_IDLE;
            if (prev_clk_ff && !req_clk_level) begin
               phase_in      = PH_WAIT;
               wait_timer_in = '0;
            end
         end
      endcase

      // step once the clock reads high, then re-arm
      if (phase_in == PH_HIGH && req_clk_level) begin
         if (req_dt_level) begin
            if (count_ff < limit) begin
               count_in = count_ff + COUNT_W'(1);
            end
         end else begin
            if (count_ff != '0) begin
               count_in = count_ff - COUNT_W'(1);
            end
         end
         changed_in    = 1'b1;
         phase_in      = PH_IDLE;
         wait_timer_in = '0;
      end
   end

   // Tracker state registers, advance on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         wait_timer_ff <= '0;
         prev_clk_ff   <= 1'b1;
         count_ff      <= '0;
      end else if (req_fire) begin
         phase_ff      <= phase_in;
         wait_timer_ff <= wait_timer_in;
         prev_clk_ff   <= req_clk_level;
         count_ff      <= count_in;
      end
   end

   // Response valid: set on accept, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload, hold while stalled
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_count_ff   <= count_in;
         rsp_seg_ff     <= seg_decode_n(count_in);
         rsp_changed_ff <= changed_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_count_value   = rsp_count_ff;
   assign rsp_segments_n    = rsp_seg_ff;
   assign rsp_count_changed = rsp_changed_ff;

   // Count never leaves the digit range
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DIGIT_LIMIT)
      else $error("count left digit range");

   // Count moves only on an accepted request
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(count_ff))
      else $error("count changed without a request");

   // A step is only reported out of the wait or high phase
   a_step_phase: assert property (@(posedge clock) disable iff (reset)
      (req_fire && changed_in) |-> (phase_ff == PH_WAIT || phase_ff == PH_HIGH))
      else $error("step reported from idle phase");

   // An empty response register never blocks a request
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("request blocked with empty response register");

endmodule
